>>> rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// Key-value table package
// Shared codes, fixed field widths and the per-cell command word.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 64;
   localparam int ACTION_W    = 2;
   localparam int INDEX_OUT_W = 7;
   localparam int COUNT_OUT_W = 8;

   localparam int DEFAULT_DEPTH      = 128;
   localparam int DEFAULT_KEY_BITS   = 64;
   localparam int DEFAULT_VALUE_BITS = 64;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;

   typedef struct packed {
      logic update_en;
      logic append_en;
      logic remove_en;
   } kvt_op_type;

endpackage

>>> rtl/core/kvt_cell.sv
// ----------------------------------------------------------------------------
// Key-value table cell
// Holds one entry, compares it against the request key and passes the first
// hit down the chain; shifts from its right neighbor on remove.
// ----------------------------------------------------------------------------
module kvt_cell #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int IDX_W      = 7,
   parameter int CNT_W      = 8,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  logic [CNT_W-1:0]       count,
   input  logic [IDX_W-1:0]       hit_pos,
   input  kvt_pkg::kvt_op_type    op,
   input  logic [KEY_BITS-1:0]    next_key,
   input  logic [VALUE_BITS-1:0]  next_value,
   input  logic                   carry_hit,
   input  logic [IDX_W-1:0]       carry_idx,
   input  logic [VALUE_BITS-1:0]  carry_value,
   output logic [KEY_BITS-1:0]    key_out,
   output logic [VALUE_BITS-1:0]  value_out,
   output logic                   pass_hit,
   output logic [IDX_W-1:0]       pass_idx,
   output logic [VALUE_BITS-1:0]  pass_value
);
   import kvt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

   logic [KEY_BITS-1:0]   key_ff,   key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  hit_ff,   hit_in;
   logic [IDX_W-1:0]      idx_ff,   idx_in;
   logic [VALUE_BITS-1:0] cval_ff,  cval_in;
   logic                  match;

   assign match = (key_ff == req_key) && (MY_CNT < count);

   always_comb begin
      if (carry_hit) begin
         hit_in  = 1'b1;
         idx_in  = carry_idx;
         cval_in = carry_value;
      end else if (match) begin
         hit_in  = 1'b1;
         idx_in  = MY_IDX;
         cval_in = value_ff;
      end else begin
         hit_in  = 1'b0;
         idx_in  = '0;
         cval_in = '0;
      end
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (op.remove_en && (MY_IDX >= hit_pos)) begin
         key_in   = next_key;
         value_in = next_value;
      end
      if (op.update_en && (MY_IDX == hit_pos)) begin
         value_in = req_value;
      end
      if (op.append_en && (MY_CNT == count)) begin
         key_in   = req_key;
         value_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      cval_ff  <= cval_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign key_out    = key_ff;
   assign value_out  = value_ff;
   assign pass_hit   = hit_ff;
   assign pass_idx   = idx_ff;
   assign pass_value = cval_ff;

endmodule

>>> rtl/core/compacting_key_value_table.sv
// ----------------------------------------------------------------------------
// Compacting key-value table
// Insertion-ordered table of key/value entries held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_action, req_key and req_value with start high; the word is taken
//   at a clock edge where start is high and busy is low. busy stays high until
//   the result has been produced.
//   Every request gives one result word, shown for one cycle with rsp_strobe
//   high. The receiver cannot stall the block; it must take each result word.
//   The result follows the hit search, which walks the chain of cells one cell
//   per cycle, and then the table update (ST_APPLY); no new request is taken
//   before the result word is shown. Remove shifts every later entry down one
//   cell in that update.
//   Reset empties the table (entry count zero) and clears busy and the strobe;
//   entry contents are not cleared.
// ----------------------------------------------------------------------------
module compacting_key_value_table #(
   parameter int TABLE_DEPTH = kvt_pkg::DEFAULT_DEPTH,
   parameter int KEY_BITS    = kvt_pkg::DEFAULT_KEY_BITS,
   parameter int VALUE_BITS  = kvt_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [kvt_pkg::ACTION_W-1:0]      req_action,
   input  logic [kvt_pkg::KEY_W-1:0]         req_key,
   input  logic [kvt_pkg::VALUE_W-1:0]       req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [kvt_pkg::INDEX_OUT_W-1:0]   rsp_entry_index,
   output logic [kvt_pkg::VALUE_W-1:0]       rsp_stored_value,
   output logic [kvt_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                              rsp_full_error
);
   import kvt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]            state_ff,  state_in;
   logic [IDX_W-1:0]      scan_ff,   scan_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   logic [ACTION_W-1:0]   act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   logic                  strobe_ff;
   logic                  found_ff;
   logic [INDEX_OUT_W-1:0] index_ff;
   logic [VALUE_W-1:0]    stored_ff;
   logic [COUNT_OUT_W-1:0] rcount_ff;
   logic                  full_ff;

   logic                  accept;
   logic                  applying;
   logic                  is_insert;
   logic                  is_remove;
   logic                  hit;
   logic [IDX_W-1:0]      hit_pos;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  full;
   kvt_op_type            op;

   logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
   logic                  chain_hit  [TABLE_DEPTH+1];
   logic [IDX_W-1:0]      chain_idx  [TABLE_DEPTH+1];
   logic [VALUE_BITS-1:0] chain_value[TABLE_DEPTH+1];

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign applying = (state_ff == ST_APPLY);

   assign chain_hit[0]   = 1'b0;
   assign chain_idx[0]   = '0;
   assign chain_value[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         logic [KEY_BITS-1:0]   nb_key;
         logic [VALUE_BITS-1:0] nb_value;
         if (gi == TABLE_DEPTH - 1) begin : g_last
            assign nb_key   = cell_key[gi];
            assign nb_value = cell_value[gi];
         end else begin : g_mid
            assign nb_key   = cell_key[gi+1];
            assign nb_value = cell_value[gi+1];
         end
         kvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .req_key     (key_ff),
            .req_value   (value_ff),
            .count       (count_ff),
            .hit_pos     (hit_pos),
            .op          (op),
            .next_key    (nb_key),
            .next_value  (nb_value),
            .carry_hit   (chain_hit[gi]),
            .carry_idx   (chain_idx[gi]),
            .carry_value (chain_value[gi]),
            .key_out     (cell_key[gi]),
            .value_out   (cell_value[gi]),
            .pass_hit    (chain_hit[gi+1]),
            .pass_idx    (chain_idx[gi+1]),
            .pass_value  (chain_value[gi+1])
         );
      end
   endgenerate

   assign hit       = chain_hit[TABLE_DEPTH];
   assign hit_pos   = chain_idx[TABLE_DEPTH];
   assign hit_value = chain_value[TABLE_DEPTH];

   assign is_insert = (act_ff == ACT_INSERT);
   assign is_remove = (act_ff == ACT_REMOVE);
   assign full      = is_insert && !hit && (count_ff == DEPTH_C);

   assign op.update_en = applying && is_insert && hit;
   assign op.append_en = applying && is_insert && !hit && (count_ff < DEPTH_C);
   assign op.remove_en = applying && is_remove && hit;

   always_comb begin
      count_in = count_ff;
      if (op.append_en) begin
         count_in = count_ff + 1'b1;
      end else if (op.remove_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SCAN_LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         count_ff  <= count_in;
         strobe_ff <= applying;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         key_ff   <= req_key[KEY_BITS-1:0];
         value_ff <= req_value[VALUE_BITS-1:0];
      end
      if (applying) begin
         found_ff  <= hit;
         index_ff  <= INDEX_OUT_W'(hit_pos);
         stored_ff <= VALUE_W'(hit_value);
         rcount_ff <= COUNT_OUT_W'(count_in);
         full_ff   <= full;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_found        = found_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_stored_value = stored_ff;
   assign rsp_entry_count  = rcount_ff;
   assign rsp_full_error   = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low after accepted request");

   a_apply_strobe: assert property (@(posedge clock) disable iff (reset)
      applying |=> rsp_strobe)
      else $error("no result word after update cycle");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_full_error) |-> !rsp_found)
      else $error("full error on a present key");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      op.remove_en |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not drop the entry count");

endmodule
